[design/h74dp_pkg.sv]
// ----------------------------------------------------------------------------
// h74dp_pkg
// Shared constants and types for the Hamming(7,4) decode and pack block.
// ----------------------------------------------------------------------------
package h74dp_pkg;

   localparam int CODE_WIDTH          = 7;
   localparam int NIBBLE_WIDTH        = 4;
   localparam int BYTE_WIDTH          = 8;
   localparam int ERRS_WIDTH          = 2;
   localparam int TOTAL_WIDTH         = 32;
   localparam int RSP_DATA_WIDTH      = 48;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // parity groups over positions 1..7 (bit0 is position 1)
   localparam logic [CODE_WIDTH-1:0] GROUP_P1 = 7'b1010101;
   localparam logic [CODE_WIDTH-1:0] GROUP_P2 = 7'b1100110;
   localparam logic [CODE_WIDTH-1:0] GROUP_P3 = 7'b1111000;

   typedef struct packed {
      logic [NIBBLE_WIDTH-1:0] nibble;
      logic                    err;
   } decode_type;

endpackage

[design/h74dp_decode.sv]
// ----------------------------------------------------------------------------
// h74dp_decode
// Syndrome, single-bit correction and data nibble extraction for one codeword.
// ----------------------------------------------------------------------------
module h74dp_decode (
   input  logic [h74dp_pkg::CODE_WIDTH-1:0] code,
   input  logic                             correct_en,
   output h74dp_pkg::decode_type            result
);
   import h74dp_pkg::*;

   logic [2:0]            syndrome;
   logic [CODE_WIDTH-1:0] flip;
   logic [CODE_WIDTH-1:0] fixed;

   assign syndrome = {^(code & GROUP_P3), ^(code & GROUP_P2), ^(code & GROUP_P1)};

   // syndrome names the position, 1-based
   assign flip  = (correct_en && (syndrome != 3'd0))
                  ? (CODE_WIDTH'(1) << (syndrome - 3'd1)) : '0;
   assign fixed = code ^ flip;

   assign result.nibble = {fixed[6], fixed[5], fixed[4], fixed[2]};
   assign result.err    = (syndrome != 3'd0);

endmodule

[design/hamming74_decode_pack.sv]
// ----------------------------------------------------------------------------
// hamming74_decode_pack
// Hamming(7,4) decoder that packs two data nibbles per output byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one codeword per transaction (tdata[6:0], bit 7 ignored),
//   req_tlast marks the last codeword of a buffer. rsp_* returns one byte per
//   pair of codewords; an odd final codeword gives a byte with its nibble in
//   the upper half and zero below. rsp_tlast closes the buffer.
//   csr_* writes correct_enable (1 = correct single errors, 0 = detect only);
//   write it only while no transaction is in flight.
// Path: a codeword is registered at the input, then decoded and packed
//   into the output register; rsp_tvalid rises when the codeword that
//   completes the pair moves from the input register to the output register.
// Throughput: one codeword per cycle while the output is not stalled, set by
//   the single decode stage between the input register and the output register.
// Reset: clears the pending nibble, the error counter and both valid flags;
//   correct_enable returns to 1.
// Stall: while rsp_tready is low the output holds; the input register takes
//   one more codeword, and an unpaired first nibble still moves on to the
//   holding register, after which req_tready drops.
// ----------------------------------------------------------------------------
module hamming74_decode_pack #(
   parameter int COUNT_WIDTH = h74dp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [h74dp_pkg::BYTE_WIDTH-1:0]      req_tdata,  // [7:0] code_word
   input  logic                                  req_tlast,  // last_item
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] data_byte, [9:8] nibble_errors, [41:10] error_total, rest zero
   output logic [h74dp_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                  rsp_tlast,  // last_out
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_data    // correct_enable
);
   import h74dp_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic                    correct_en_ff;
   logic                    s1_valid_ff;
   logic [CODE_WIDTH-1:0]   s1_code_ff;
   logic                    s1_last_ff;
   logic [NIBBLE_WIDTH-1:0] held_nibble_ff;
   logic                    pend_ff;
   logic                    held_err_ff;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [COUNT_WIDTH-1:0]  count_in;
   logic                    rsp_valid_ff;
   logic [BYTE_WIDTH-1:0]   data_byte_ff;
   logic [ERRS_WIDTH-1:0]   nib_errs_ff;
   logic [TOTAL_WIDTH-1:0]  total_ff;
   logic                    last_out_ff;

   decode_type              dec;
   logic                    produces;
   logic                    out_free;
   logic                    s1_fire;
   logic [63:0]             count_wide;

   h74dp_decode u_decode (
      .code       (s1_code_ff),
      .correct_en (correct_en_ff),
      .result     (dec)
   );

   assign produces   = pend_ff || s1_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && (!produces || out_free);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign csr_ready  = 1'b1;

   assign count_in   = (s1_fire && dec.err && (count_ff != COUNT_MAX))
                       ? count_ff + COUNT_WIDTH'(1) : count_ff;
   assign count_wide = 64'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         correct_en_ff <= 1'b1;
         s1_valid_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         held_nibble_ff <= '0;
         held_err_ff   <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            correct_en_ff <= csr_data;
         end

         if (req_tvalid && req_tready) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end

         count_ff <= count_in;

         if (s1_fire) begin
            if (pend_ff) begin
               pend_ff        <= 1'b0;
               held_nibble_ff <= '0;
               held_err_ff    <= 1'b0;
            end else if (!s1_last_ff) begin
               pend_ff        <= 1'b1;
               held_nibble_ff <= dec.nibble;
               held_err_ff    <= dec.err;
            end
         end

         if (s1_fire && produces) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_code_ff <= req_tdata[CODE_WIDTH-1:0];
         s1_last_ff <= req_tlast;
      end
      if (s1_fire && produces) begin
         if (pend_ff) begin
            data_byte_ff <= {held_nibble_ff, dec.nibble};
            nib_errs_ff  <= ERRS_WIDTH'(held_err_ff) + ERRS_WIDTH'(dec.err);
         end else begin
            data_byte_ff <= {dec.nibble, {NIBBLE_WIDTH{1'b0}}};
            nib_errs_ff  <= ERRS_WIDTH'(dec.err);
         end
         total_ff    <= count_wide[TOTAL_WIDTH-1:0];
         last_out_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_out_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - BYTE_WIDTH - ERRS_WIDTH - TOTAL_WIDTH){1'b0}},
                        total_ff, nib_errs_ff, data_byte_ff};

   // error counter moves by at most one per cycle and never falls
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + COUNT_WIDTH'(1)))
      else $error("error counter stepped by more than one");

   // a codeword that completes a pair empties the holding register
   a_pair_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && pend_ff) |=> !pend_ff)
      else $error("holding register not cleared after pair");

   // a byte never counts more than two bad codewords
   a_errs_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (nib_errs_ff != 2'd3))
      else $error("nibble error count out of range");

   // the decode stage never overwrites a result the receiver has not taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(s1_fire && produces))
      else $error("output overwritten while stalled");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Hamming(7,4) decode and pack block.
// Codewords are queued by a stimulus process and fed by a clocked driver. Each
// accepted codeword runs through a local decoder model that predicts the
// packed byte, if any. A clocked monitor checks every returned byte, field by
// field, against the oldest prediction. Both sides idle at random over
// several phases, with both settings of the correction enable.
// ----------------------------------------------------------------------------
module tb;
   import h74dp_pkg::*;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 8;

   typedef struct {
      logic [BYTE_WIDTH-1:0] code;
      logic                  last;
   } codeword_type;

   typedef struct {
      logic [BYTE_WIDTH-1:0]  data_byte;
      logic [ERRS_WIDTH-1:0]  nibble_errors;
      logic [TOTAL_WIDTH-1:0] error_total;
      logic                   last_out;
   } packed_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [BYTE_WIDTH-1:0]     req_tdata  = '0;
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic                      csr_data   = 1'b0;

   // decoder model state
   logic                           model_correct = 1'b1;
   logic [NIBBLE_WIDTH-1:0]        model_held_nibble = '0;
   logic                           model_pending = 1'b0;
   logic                           model_held_err = 1'b0;
   logic [COUNT_WIDTH_DEFAULT-1:0] model_err_count = '0;

   codeword_type    pending_codewords[$];
   packed_byte_type expected_bytes[$];
   codeword_type    next_codeword;
   packed_byte_type want;

   int queued_count   = 0;
   int accepted_count = 0;
   int mismatches     = 0;
   int tx_idle_pct    = 0;
   int rx_stall_pct   = 0;
   int hold_left      = 0;
   logic hold_kick    = 1'b0;

   hamming74_decode_pack DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Decode one codeword, advance the model and queue the byte it completes.
   function automatic void predict_codeword(input logic [BYTE_WIDTH-1:0] code,
                                            input logic last);
      logic [CODE_WIDTH-1:0]   w;
      logic [2:0]              syn;
      logic                    err;
      logic [NIBBLE_WIDTH-1:0] nib;
      packed_byte_type         b;
      w      = code[CODE_WIDTH-1:0];
      syn[0] = ^(w & GROUP_P1);
      syn[1] = ^(w & GROUP_P2);
      syn[2] = ^(w & GROUP_P3);
      err    = |syn;
      if (model_correct && err)
         w[syn - 3'd1] = ~w[syn - 3'd1];
      nib = {w[6], w[5], w[4], w[2]};
      if (err && model_err_count != '1)
         model_err_count = model_err_count + 1'b1;
      if (model_pending) begin
         b.data_byte     = {model_held_nibble, nib};
         b.nibble_errors = ERRS_WIDTH'(model_held_err) + ERRS_WIDTH'(err);
         b.error_total   = model_err_count[TOTAL_WIDTH-1:0];
         b.last_out      = last;
         expected_bytes.push_back(b);
         model_pending     = 1'b0;
         model_held_nibble = '0;
         model_held_err    = 1'b0;
      end else if (last) begin
         // odd final nibble goes out alone in the upper half
         b.data_byte     = {nib, 4'h0};
         b.nibble_errors = ERRS_WIDTH'(err);
         b.error_total   = model_err_count[TOTAL_WIDTH-1:0];
         b.last_out      = 1'b1;
         expected_bytes.push_back(b);
      end else begin
         model_held_nibble = nib;
         model_held_err    = err;
         model_pending     = 1'b1;
      end
   endfunction

   function automatic logic [CODE_WIDTH-1:0] encode_nibble(input logic [3:0] n);
      return {n[3], n[2], n[1], n[1] ^ n[2] ^ n[3], n[0], n[0] ^ n[2] ^ n[3],
              n[0] ^ n[1] ^ n[3]};
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] random_code();
      logic [CODE_WIDTH-1:0] w;
      int a;
      int b;
      w = encode_nibble(4'($urandom));
      a = $urandom_range(0, 6);
      b = (a + 1 + $urandom_range(0, 5)) % 7;
      case ($urandom_range(0, 9))
         0, 1:    return 8'($urandom);
         2, 3, 4: w[a] = ~w[a];
         5: begin
            w[a] = ~w[a];
            w[b] = ~w[b];
         end
         default: ;
      endcase
      return {1'($urandom), w};
   endfunction

   task automatic queue_codeword(input logic [BYTE_WIDTH-1:0] code, input logic last);
      codeword_type c;
      c.code = code;
      c.last = last;
      pending_codewords.push_back(c);
      queued_count++;
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++)
         queue_codeword(random_code(), $urandom_range(0, 7) == 0);
   endtask

   // Sender pauses here until every byte has come back and the pipe is quiet.
   task automatic drain();
      while (accepted_count != queued_count) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_correct_enable(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      model_correct = value;
      csr_valid <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_codeword(req_tdata, req_tlast);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_codewords.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               next_codeword = pending_codewords.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_codeword.code;
               req_tlast  <= next_codeword.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold, counted here
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_kick && hold_left == 0)
         hold_left <= LONG_HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && hold_left == 0 && !hold_kick &&
                    $urandom_range(0, 99) >= rx_stall_pct;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result transaction: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata[7:0] !== want.data_byte) begin
               $error("data_byte: expected %h, got %h", want.data_byte, rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tdata[9:8] !== want.nibble_errors) begin
               $error("nibble_errors: expected %0d, got %0d",
                      want.nibble_errors, rsp_tdata[9:8]);
               mismatches++;
            end
            if (rsp_tdata[41:10] !== want.error_total) begin
               $error("error_total: expected %0d, got %0d", want.error_total, rsp_tdata[41:10]);
               mismatches++;
            end
            if (rsp_tdata[RSP_DATA_WIDTH-1:42] !== '0) begin
               $error("tdata padding: expected 0, got %h", rsp_tdata[RSP_DATA_WIDTH-1:42]);
               mismatches++;
            end
            if (rsp_tlast !== want.last_out) begin
               $error("last_out: expected %b, got %b", want.last_out, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed, correction on: single error at every position, extremes,
      // a double error, an odd final nibble and a pair that closes a buffer
      write_correct_enable(1'b1);
      for (int p = 0; p < CODE_WIDTH; p++)
         queue_codeword({1'b0, encode_nibble(4'(p + 9)) ^ 7'(1 << p)}, 1'b0);
      queue_codeword(8'h00, 1'b0);
      queue_codeword(8'h7F, 1'b0);
      queue_codeword(8'hFF, 1'b0);
      queue_codeword(8'h80, 1'b0);
      queue_codeword({1'b1, encode_nibble(4'h5) ^ 7'b0000011}, 1'b0);
      queue_codeword({1'b0, encode_nibble(4'hA)}, 1'b1);
      queue_codeword({1'b0, encode_nibble(4'hF)}, 1'b0);
      queue_codeword({1'b1, encode_nibble(4'h0) ^ 7'b1000000}, 1'b1);
      drain();

      // directed, detect only
      write_correct_enable(1'b0);
      queue_codeword({1'b0, encode_nibble(4'h3) ^ 7'b0000100}, 1'b0);
      queue_codeword({1'b1, encode_nibble(4'hC) ^ 7'b0010000}, 1'b0);
      queue_codeword(8'hFF, 1'b0);
      queue_codeword({1'b0, encode_nibble(4'h6) ^ 7'b0000001}, 1'b1);
      queue_codeword(8'h00, 1'b0);
      drain();

      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      write_correct_enable(1'b1);
      queue_random(475);
      drain();

      tx_idle_pct  = 80;
      rx_stall_pct = 0;
      write_correct_enable(1'b0);
      queue_random(475);
      drain();

      tx_idle_pct  = 0;
      rx_stall_pct = 80;
      write_correct_enable(1'b1);
      queue_random(475);
      drain();

      tx_idle_pct  = 10;
      rx_stall_pct = 10;
      write_correct_enable(1'b0);
      queue_random(475);
      drain();

      // back-pressure: receiver holds off while the sender keeps offering
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      write_correct_enable(1'b1);
      queue_random(100);
      @(posedge clock);
      hold_kick = 1'b1;
      while (hold_left == 0) @(posedge clock);
      hold_kick = 1'b0;
      drain();

      if (mismatches == 0 && expected_bytes.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
